>>> sv/pmpu_pkg.sv
// Shared types, codes and helper functions of the power monitor packet unpacker.
// Used by the top level, the controller and the datapath; depends on nothing.
`default_nettype none

package pmpu_pkg;

    // Header command that marks a measurement packet
    localparam logic [7:0] DATA_CMD = 8'h0C;

    // Header flag bits
    localparam int FLAG_EMPTY = 7;
    localparam int FLAG_OVF   = 6;
    localparam int FLAG_GPIO  = 4;

    // Header layout
    localparam int HDR_LAST_BYTE  = 15;
    localparam int HDR_BYTES      = 16;
    localparam int TIMER_BITS     = 32;
    localparam int CHAN_SLOTS     = 32;

    // Packet status codes
    localparam logic [2:0] ST_GOOD     = 3'd0;
    localparam logic [2:0] ST_BAD_CMD  = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_INVALID  = 3'd3;
    localparam logic [2:0] ST_GPIO_OFF = 3'd4;

    // Result and channel kinds
    localparam logic       RES_SAMPLE = 1'b0;
    localparam logic       RES_STATUS = 1'b1;
    localparam logic [1:0] KIND_VOLT  = 2'd0;
    localparam logic [1:0] KIND_CURR  = 2'd1;
    localparam logic [1:0] KIND_GPIO  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_NUM_BUSES = 3'd0;
    localparam logic [2:0] CFG_GPIO_EN   = 3'd1;
    localparam logic [2:0] CFG_TMASK     = 3'd2;
    localparam logic [2:0] CFG_BUS0_EN   = 3'd3;
    localparam logic [2:0] CFG_BUS1_EN   = 3'd4;
    localparam logic [2:0] CFG_BUS2_EN   = 3'd5;
    localparam logic [2:0] CFG_BUS3_EN   = 3'd6;

    // Controller states, one-hot
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_BYTE = 7'b0000010,
        S_POPC = 7'b0000100,
        S_SDIV = 7'b0001000,
        S_PSET = 7'b0010000,
        S_PDIV = 7'b0100000,
        S_STAT = 7'b1000000
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic step;
        logic popc;
        logic sets_load;
        logic per_start;
        logic per_load;
        logic status_load;
    } t_ctl_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic out_full;
        logic hdr_end;
        logic hdr_ok;
        logic last_now;
        logic last_held;
        logic need_sdiv;
        logic need_pdiv;
        logic div_done;
    } t_dp_stat;

    // Count set bits of a 32-bit word
    function automatic logic [5:0] count_ones(input logic [31:0] v);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < 32; i++) begin
            n = n + 6'(v[i]);
        end
        return n;
    endfunction

    // Index of the lowest set bit of a 32-bit word, 0 if none
    function automatic logic [4:0] lowest_set(input logic [31:0] v);
        logic [4:0] idx;
        idx = '0;
        for (int i = 31; i >= 0; i--) begin
            if (v[i]) begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

>>> sv/power_monitor_packet_unpacker.sv
// Top level of the power monitor packet unpacker: joins controller and datapath.
// Depends on pmpu_pkg, pmpu_ctrl, pmpu_dp (and pmpu_div below it).
//
//   channel  direction  handshake                 payload
//   input    in         i_in_valid / o_in_stall   i_packet_byte, i_packet_start
//   output   out        o_out_valid / i_out_stall result_kind .. last
//   config   in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// A byte is accepted in S_IDLE, then stepped into the packet state in S_BYTE.
// A good last header byte then goes through S_POPC, S_SDIV when the set count needs a
// division, S_PSET, and S_PDIV when the set period needs one; both use the shared divider.
// A status result on a packet's last byte is loaded in S_STAT.
// A result waits in the output register while i_out_stall is high; a captured
// byte holds until it is taken.
// Reset (synchronous, active low) clears the packet state and configuration, but not the held byte.
`default_nettype none

module power_monitor_packet_unpacker #(
    parameter int PACKET_BYTES     = 64,
    parameter int MAX_SAMPLES      = 24,
    parameter int CHANNELS_PER_BUS = 32,
    parameter int BUS_COUNT        = 4
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire  [2:0]         i_cfg_index,
    input  wire  [31:0]        i_cfg_data,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire  [7:0]         i_packet_byte,
    input  wire                i_packet_start,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic               o_result_kind,
    output logic [6:0]         o_channel_number,
    output logic [1:0]         o_channel_kind,
    output logic signed [15:0] o_raw_code,
    output logic [31:0]        o_time_stamp,
    output logic [2:0]         o_packet_status,
    output logic               o_overflowed,
    output logic               o_last
);

    pmpu_pkg::t_ctl_cmd cmd;
    pmpu_pkg::t_dp_stat stat;

    pmpu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pmpu_dp #(
        .PACKET_BYTES     (PACKET_BYTES),
        .MAX_SAMPLES      (MAX_SAMPLES),
        .CHANNELS_PER_BUS (CHANNELS_PER_BUS),
        .BUS_COUNT        (BUS_COUNT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_packet_byte    (i_packet_byte),
        .i_packet_start   (i_packet_start),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_result_kind    (o_result_kind),
        .o_channel_number (o_channel_number),
        .o_channel_kind   (o_channel_kind),
        .o_raw_code       (o_raw_code),
        .o_time_stamp     (o_time_stamp),
        .o_packet_status  (o_packet_status),
        .o_overflowed     (o_overflowed),
        .o_last           (o_last)
    );

endmodule

`default_nettype wire

>>> sv/pmpu_div.sv
// Shared restoring divider of the packet unpacker, one quotient bit per cycle.
// Depends on nothing but its ports.
`default_nettype none

module pmpu_div (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [31:0] i_dividend,
    input  wire  [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient,
    output logic [31:0] o_remainder
);

    logic [32:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_div;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] n_shift;
    logic        n_fit;

    // One restoring step
    always_comb begin
        n_shift = {r_rem[31:0], r_quo[31]};
        n_fit   = n_shift >= {1'b0, r_div};
    end

    // Control of the iteration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift the partial remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_fit ? (n_shift - {1'b0, r_div}) : n_shift;
            r_quo <= {r_quo[30:0], n_fit};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem[31:0];

endmodule

`default_nettype wire

>>> sv/pmpu_ctrl.sv
// Controller state machine of the packet unpacker: sequences byte steps,
// header decode, the two divisions and status results. Uses pmpu_pkg.
`default_nettype none

module pmpu_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  pmpu_pkg::t_dp_stat  i_stat,
    output pmpu_pkg::t_ctl_cmd  o_cmd
);

    pmpu_pkg::t_state r_state;
    pmpu_pkg::t_state n_state;
    pmpu_pkg::t_state n_after;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_after = i_stat.last_held ? pmpu_pkg::S_STAT : pmpu_pkg::S_IDLE;
        case (r_state)
            pmpu_pkg::S_IDLE: begin
                // take the next byte
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = pmpu_pkg::S_BYTE;
                end
            end
            pmpu_pkg::S_BYTE: begin
                // process once the result register is free
                if (!i_stat.out_full) begin
                    o_cmd.step = 1'b1;
                    if (i_stat.hdr_end && i_stat.hdr_ok) begin
                        n_state = pmpu_pkg::S_POPC;
                    end else if (i_stat.last_now) begin
                        n_state = pmpu_pkg::S_STAT;
                    end else begin
                        n_state = pmpu_pkg::S_IDLE;
                    end
                end
            end
            pmpu_pkg::S_POPC: begin
                o_cmd.popc = 1'b1;
                n_state    = i_stat.need_sdiv ? pmpu_pkg::S_SDIV : pmpu_pkg::S_PSET;
            end
            pmpu_pkg::S_SDIV: begin
                if (i_stat.div_done) begin
                    o_cmd.sets_load = 1'b1;
                    n_state         = pmpu_pkg::S_PSET;
                end
            end
            pmpu_pkg::S_PSET: begin
                if (i_stat.need_pdiv) begin
                    o_cmd.per_start = 1'b1;
                    n_state         = pmpu_pkg::S_PDIV;
                end else begin
                    n_state = n_after;
                end
            end
            pmpu_pkg::S_PDIV: begin
                if (i_stat.div_done) begin
                    o_cmd.per_load = 1'b1;
                    n_state        = n_after;
                end
            end
            pmpu_pkg::S_STAT: begin
                if (!i_stat.out_full) begin
                    o_cmd.status_load = 1'b1;
                    n_state           = pmpu_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pmpu_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pmpu_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != pmpu_pkg::S_IDLE);

endmodule

`default_nettype wire

>>> sv/pmpu_dp.sv
// Datapath of the packet unpacker: configuration, header registers, sample
// timing, channel walk and the result register. Uses pmpu_pkg and pmpu_div.
`default_nettype none

module pmpu_dp #(
    parameter int PACKET_BYTES     = 64,
    parameter int MAX_SAMPLES      = 24,
    parameter int CHANNELS_PER_BUS = 32,
    parameter int BUS_COUNT        = 4
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire  [2:0]          i_cfg_index,
    input  wire  [31:0]         i_cfg_data,
    input  wire  [7:0]          i_packet_byte,
    input  wire                 i_packet_start,
    input  pmpu_pkg::t_ctl_cmd  i_cmd,
    output pmpu_pkg::t_dp_stat  o_stat,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output logic                o_result_kind,
    output logic [6:0]          o_channel_number,
    output logic [1:0]          o_channel_kind,
    output logic signed [15:0]  o_raw_code,
    output logic [31:0]         o_time_stamp,
    output logic [2:0]          o_packet_status,
    output logic                o_overflowed,
    output logic                o_last
);

    localparam int PW = $clog2(PACKET_BYTES);

    // configuration
    logic [2:0]  r_num_buses;
    logic        r_gpio_en;
    logic [31:0] r_tmask;
    logic [31:0] r_bus_en [4];

    // packet state
    logic [7:0]    r_byte;
    logic          r_start;
    logic [PW-1:0] r_pos;
    logic          r_was_last;
    logic [7:0]    r_cmd;
    logic [7:0]    r_flags;
    logic [7:0]    r_cnt;
    logic [7:0]    r_first;
    logic [31:0]   r_mask;
    logic [31:0]   r_start_st;
    logic [31:0]   r_end_st;
    logic [31:0]   r_period;
    logic [31:0]   r_time;
    logic [4:0]    r_cursor;
    logic [7:0]    r_done;
    logic [7:0]    r_low;
    logic [2:0]    r_status;
    logic [7:0]    r_sets;

    // result register
    logic        r_out_valid;
    logic        r_o_kind;
    logic [6:0]  r_o_chan;
    logic [1:0]  r_o_ckind;
    logic [15:0] r_o_raw;
    logic [31:0] r_o_time;
    logic [2:0]  r_o_status;
    logic        r_o_ovf;
    logic        r_o_last;

    // combinational helpers
    logic [PW-1:0] n_pos;
    logic [8:0]    n_pos9;
    logic [3:0]    n_bus;
    logic          n_gpio;
    logic [2:0]    n_st;
    logic          n_early;
    logic          n_odd;
    logic          n_sample;
    logic [31:0]   n_en;
    logic [31:0]   n_room;
    logic [31:0]   n_time_adv;
    logic [31:0]   n_hi;
    logic [5:0]    n_nen;
    logic [5:0]    n_idx;
    logic [5:0]    n_nfirst;
    logic [7:0]    n_rest;
    logic [31:0]   n_s;
    logic [31:0]   n_e;
    logic [31:0]   n_span;
    logic [10:0]   n_chan;
    logic [31:0]   n_below;

    // shared divider
    logic        div_start;
    logic [31:0] div_a;
    logic [31:0] div_b;
    logic        div_done;
    logic [31:0] div_q;
    logic [31:0] div_r;

    // Decode the current byte and header checks
    always_comb begin
        n_pos   = r_start ? '0 : r_pos;
        n_pos9  = 9'(n_pos);
        n_bus   = r_flags[3:0];
        n_gpio  = r_flags[pmpu_pkg::FLAG_GPIO];
        n_early = (r_cmd == pmpu_pkg::DATA_CMD) && !r_flags[pmpu_pkg::FLAG_EMPTY]
                  && (r_cnt != 8'd0) && (r_cnt <= 8'(MAX_SAMPLES));

        n_st = pmpu_pkg::ST_GOOD;
        if (r_cmd != pmpu_pkg::DATA_CMD) begin
            n_st = pmpu_pkg::ST_BAD_CMD;
        end else if (r_flags[pmpu_pkg::FLAG_EMPTY]) begin
            n_st = pmpu_pkg::ST_EMPTY;
        end else if ((r_cnt == 8'd0) || (r_cnt > 8'(MAX_SAMPLES))) begin
            n_st = pmpu_pkg::ST_INVALID;
        end else begin
            if (n_gpio) begin
                if (!r_gpio_en) begin
                    n_st = pmpu_pkg::ST_GPIO_OFF;
                end
            end else if ((n_bus >= {1'b0, r_num_buses}) || (5'(n_bus) >= 5'(BUS_COUNT))) begin
                n_st = pmpu_pkg::ST_INVALID;
            end
            if ((n_st == pmpu_pkg::ST_GOOD) && (r_mask == 32'd0)) begin
                n_st = pmpu_pkg::ST_INVALID;
            end
            if ((n_st == pmpu_pkg::ST_GOOD) && !n_gpio &&
                ((r_first >= 8'(pmpu_pkg::CHAN_SLOTS)) || !r_mask[r_first[4:0]])) begin
                n_st = pmpu_pkg::ST_INVALID;
            end
        end

        // reading completion and emission
        n_odd    = (n_pos9 >= 9'(pmpu_pkg::HDR_BYTES)) && n_pos[0];
        n_sample = n_odd && (r_status == pmpu_pkg::ST_GOOD) && (r_done < r_cnt);
        n_en     = (n_bus < 4'd4) ? r_bus_en[n_bus[1:0]] : 32'd0;
        n_chan   = 11'(n_bus) * 11'(CHANNELS_PER_BUS) + 11'(r_cursor);

        // wrap-aware time advance
        n_room     = r_tmask - r_time;
        n_time_adv = (n_room >= r_period) ? (r_time + r_period) : (r_period - n_room);

        // next enabled channel above the cursor
        n_hi = r_mask & (32'hFFFF_FFFE << r_cursor);

        // sets from enabled channel counts
        n_below  = r_mask & ((32'd1 << r_first[4:0]) - 32'd1);
        n_nen    = pmpu_pkg::count_ones(r_mask);
        n_idx    = pmpu_pkg::count_ones(n_below);
        n_nfirst = n_nen - n_idx;
        n_rest   = r_cnt - {2'b00, n_nfirst};

        // span between first and last set
        n_s    = r_tmask - r_start_st;
        n_e    = r_tmask - r_end_st;
        n_span = (n_e > n_s) ? (n_e - n_s) : (r_tmask - n_s + n_e);
    end

    // Divider operands
    always_comb begin
        div_start = (i_cmd.popc && o_stat.need_sdiv) || i_cmd.per_start;
        div_a     = i_cmd.per_start ? n_span : {24'd0, n_rest};
        div_b     = i_cmd.per_start ? {24'd0, r_sets - 8'd1} : {26'd0, n_nen};
    end

    pmpu_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_a),
        .i_divisor   (div_b),
        .o_done      (div_done),
        .o_quotient  (div_q),
        .o_remainder (div_r)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_buses <= 3'd1;
            r_gpio_en   <= 1'b0;
            r_tmask     <= 32'hFFFF_FFFF;
            r_bus_en[0] <= '0;
            r_bus_en[1] <= '0;
            r_bus_en[2] <= '0;
            r_bus_en[3] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pmpu_pkg::CFG_NUM_BUSES: r_num_buses <= i_cfg_data[2:0];
                pmpu_pkg::CFG_GPIO_EN:   r_gpio_en   <= i_cfg_data[0];
                pmpu_pkg::CFG_TMASK:     r_tmask     <= i_cfg_data;
                pmpu_pkg::CFG_BUS0_EN:   r_bus_en[0] <= i_cfg_data;
                pmpu_pkg::CFG_BUS1_EN:   r_bus_en[1] <= i_cfg_data;
                pmpu_pkg::CFG_BUS2_EN:   r_bus_en[2] <= i_cfg_data;
                pmpu_pkg::CFG_BUS3_EN:   r_bus_en[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Hold the accepted byte
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_byte  <= i_packet_byte;
            r_start <= i_packet_start;
        end
    end

    // Packet state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_was_last <= 1'b0;
            r_cmd      <= '0;
            r_flags    <= '0;
            r_cnt      <= '0;
            r_first    <= '0;
            r_mask     <= '0;
            r_start_st <= '0;
            r_end_st   <= '0;
            r_period   <= '0;
            r_time     <= '0;
            r_cursor   <= '0;
            r_done     <= '0;
            r_low      <= '0;
            r_status   <= '0;
            r_sets     <= '0;
        end else begin
            if (i_cmd.step) begin
                // store header fields
                if (n_pos9 == 9'd0) begin
                    r_cmd <= r_byte;
                end else if (n_pos9 == 9'd1) begin
                    r_flags <= r_byte;
                end else if (n_pos9 == 9'd2) begin
                    r_cnt <= r_byte;
                end else if (n_pos9 == 9'd3) begin
                    r_first <= r_byte;
                end else if (n_pos9 < 9'd8) begin
                    r_mask[n_pos[1:0]*8 +: 8] <= r_byte;
                end else if (n_pos9 < 9'd12) begin
                    r_start_st[n_pos[1:0]*8 +: 8] <= r_byte;
                end else if (n_pos9 < 9'(pmpu_pkg::HDR_BYTES)) begin
                    r_end_st[n_pos[1:0]*8 +: 8] <= r_byte;
                end else if (!n_pos[0]) begin
                    r_low <= r_byte;
                end else begin
                    // completed reading: advance time and channel
                    if (n_sample) begin
                        if (n_gpio) begin
                            r_time <= n_time_adv;
                        end else if (n_hi != 32'd0) begin
                            r_cursor <= pmpu_pkg::lowest_set(n_hi);
                        end else begin
                            r_cursor <= pmpu_pkg::lowest_set(r_mask);
                            r_time   <= n_time_adv;
                        end
                    end
                    if (r_done != 8'hFF) begin
                        r_done <= r_done + 8'd1;
                    end
                end

                // header decode on its last byte
                if (n_pos9 == 9'(pmpu_pkg::HDR_LAST_BYTE)) begin
                    r_status <= n_st;
                    r_done   <= '0;
                    r_period <= '0;
                    if (n_st == pmpu_pkg::ST_GOOD) begin
                        r_time   <= n_s;
                        r_cursor <= r_first[4:0];
                    end
                end

                // advance or wrap position
                if (o_stat.last_now) begin
                    r_pos <= '0;
                end else begin
                    r_pos <= n_pos + 1'b1;
                end
                r_was_last <= o_stat.last_now;
            end

            if (i_cmd.popc) begin
                r_sets <= n_gpio ? r_cnt : 8'd1;
            end
            if (i_cmd.sets_load) begin
                r_sets <= 8'd1 + div_q[7:0] + 8'(div_r != 32'd0);
            end
            if (i_cmd.per_load) begin
                r_period <= div_q;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.status_load || (i_cmd.step && n_sample &&
                     (n_gpio || n_en[r_cursor]))) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.status_load) begin
            r_o_kind   <= pmpu_pkg::RES_STATUS;
            r_o_chan   <= '0;
            r_o_ckind  <= pmpu_pkg::KIND_VOLT;
            r_o_raw    <= '0;
            r_o_time   <= '0;
            r_o_status <= r_status;
            r_o_ovf    <= n_early && r_flags[pmpu_pkg::FLAG_OVF];
            r_o_last   <= 1'b1;
        end else if (i_cmd.step && n_sample) begin
            r_o_kind   <= pmpu_pkg::RES_SAMPLE;
            r_o_time   <= r_time;
            r_o_status <= pmpu_pkg::ST_GOOD;
            r_o_ovf    <= 1'b0;
            r_o_last   <= 1'b0;
            if (n_gpio) begin
                r_o_chan  <= '0;
                r_o_ckind <= pmpu_pkg::KIND_GPIO;
                r_o_raw   <= {8'd0, r_low};
            end else begin
                r_o_chan  <= n_chan[6:0];
                r_o_ckind <= r_cursor[0] ? pmpu_pkg::KIND_VOLT : pmpu_pkg::KIND_CURR;
                r_o_raw   <= {r_byte, r_low};
            end
        end
    end

    // Status to the controller
    always_comb begin
        o_stat.out_full  = r_out_valid;
        o_stat.hdr_end   = (n_pos9 == 9'(pmpu_pkg::HDR_LAST_BYTE));
        o_stat.hdr_ok    = (n_st == pmpu_pkg::ST_GOOD);
        o_stat.last_now  = (n_pos9 >= 9'(PACKET_BYTES - 1));
        o_stat.last_held = r_was_last;
        o_stat.need_sdiv = !n_gpio && ({2'b00, n_nfirst} < r_cnt);
        o_stat.need_pdiv = (r_sets > 8'd1);
        o_stat.div_done  = div_done;
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_kind    = r_o_kind;
    assign o_channel_number = r_o_chan;
    assign o_channel_kind   = r_o_ckind;
    assign o_raw_code       = r_o_raw;
    assign o_time_stamp     = r_o_time;
    assign o_packet_status  = r_o_status;
    assign o_overflowed     = r_o_ovf;
    assign o_last           = r_o_last;

endmodule

`default_nettype wire
